FILE: hdl/bru_pkg.sv
package bru_pkg;

  localparam int XLEN      = 64;
  localparam int HALF      = XLEN / 2;
  localparam int TAG_W     = 7;
  localparam int PHYS_REGS = 128;
  localparam int TAG_CMP_W = 11;
  localparam int TAG_STEPS = ((1 << TAG_W) + PHYS_REGS - 1) / PHYS_REGS;

  typedef enum logic [2:0] {
    FUNC_JAL  = 3'd0,
    FUNC_JALR = 3'd1,
    FUNC_BEQ  = 3'd2,
    FUNC_BNE  = 3'd3,
    FUNC_BLT  = 3'd4,
    FUNC_BGE  = 3'd5,
    FUNC_BLTU = 3'd6,
    FUNC_BGEU = 3'd7
  } bru_func_t;

  typedef struct packed {
    logic              inst_valid;
    bru_func_t         func;
    logic [TAG_W-1:0]  tag;
    logic [HALF-1:0]   tgt_lo;
    logic              tgt_c;
    logic [HALF-1:0]   base_hi;
    logic [HALF-1:0]   off_hi;
    logic [HALF-1:0]   link_lo;
    logic              link_c;
    logic [HALF-1:0]   pc_hi;
    logic [HALF-1:0]   a_hi;
    logic [HALF-1:0]   b_hi;
    logic              eq_lo;
    logic              ltu_lo;
  } bru_s1_t;

  typedef struct packed {
    logic              inst_valid;
    bru_func_t         func;
    logic [TAG_W-1:0]  tag;
    logic [XLEN-1:0]   target;
    logic [XLEN-1:0]   link;
    logic              eq;
    logic              ltu;
    logic              lts;
  } bru_s2_t;

  function automatic logic [TAG_W-1:0] tag_wrap(input logic [TAG_W-1:0] tag);
    logic [TAG_CMP_W-1:0] t;
    t = TAG_CMP_W'(tag);
    for (int i = 0; i < TAG_STEPS; i++) begin
      if (t >= TAG_CMP_W'(PHYS_REGS)) begin
        t = t - TAG_CMP_W'(PHYS_REGS);
      end
    end
    return t[TAG_W-1:0];
  endfunction

endpackage

FILE: hdl/bru_lo_stage.sv
module bru_lo_stage
  import bru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       func,
  input  logic             inst_valid,
  input  logic [XLEN-1:0]  pc,
  input  logic [XLEN-1:0]  offset,
  input  logic [XLEN-1:0]  src_a,
  input  logic [XLEN-1:0]  src_b,
  input  logic [TAG_W-1:0] dest_tag,
  output logic             out_valid,
  input  logic             out_ready,
  output bru_s1_t          s1
);

  bru_s1_t          s1_next;
  logic [HALF-1:0]  base_lo;
  logic [HALF:0]    tgt_sum;
  logic [HALF:0]    link_sum;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    base_lo  = (bru_func_t'(func) == FUNC_JALR) ? src_a[HALF-1:0] : pc[HALF-1:0];
    tgt_sum  = {1'b0, base_lo} + {1'b0, offset[HALF-1:0]};
    link_sum = {1'b0, pc[HALF-1:0]} + (HALF+1)'(4);

    s1_next.inst_valid = inst_valid;
    s1_next.func       = bru_func_t'(func);
    s1_next.tag        = dest_tag;
    s1_next.tgt_lo     = tgt_sum[HALF-1:0];
    s1_next.tgt_c      = tgt_sum[HALF];
    s1_next.base_hi    = (bru_func_t'(func) == FUNC_JALR) ? src_a[XLEN-1:HALF] : pc[XLEN-1:HALF];
    s1_next.off_hi     = offset[XLEN-1:HALF];
    s1_next.link_lo    = link_sum[HALF-1:0];
    s1_next.link_c     = link_sum[HALF];
    s1_next.pc_hi      = pc[XLEN-1:HALF];
    s1_next.a_hi       = src_a[XLEN-1:HALF];
    s1_next.b_hi       = src_b[XLEN-1:HALF];
    s1_next.eq_lo      = (src_a[HALF-1:0] == src_b[HALF-1:0]);
    s1_next.ltu_lo     = (src_a[HALF-1:0] < src_b[HALF-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1 <= s1_next;
    end
  end

endmodule

FILE: hdl/bru_hi_stage.sv
module bru_hi_stage
  import bru_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  bru_s1_t s1,
  output logic    out_valid,
  input  logic    out_ready,
  output bru_s2_t s2
);

  bru_s2_t         s2_next;
  logic [HALF-1:0] tgt_hi;
  logic [HALF-1:0] link_hi;
  logic            eq_hi;
  logic            ltu_hi;
  logic            lts_hi;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    tgt_hi  = s1.base_hi + s1.off_hi + HALF'(s1.tgt_c);
    link_hi = s1.pc_hi + HALF'(s1.link_c);
    eq_hi   = (s1.a_hi == s1.b_hi);
    ltu_hi  = (s1.a_hi < s1.b_hi);
    lts_hi  = ($signed(s1.a_hi) < $signed(s1.b_hi));

    s2_next.inst_valid = s1.inst_valid;
    s2_next.func       = s1.func;
    s2_next.tag        = tag_wrap(s1.tag);
    s2_next.target     = {tgt_hi, s1.tgt_lo[HALF-1:1], 1'b0};
    s2_next.link       = {link_hi, s1.link_lo};
    s2_next.eq         = eq_hi && s1.eq_lo;
    s2_next.ltu        = ltu_hi || (eq_hi && s1.ltu_lo);
    s2_next.lts        = lts_hi || (eq_hi && s1.ltu_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s2 <= s2_next;
    end
  end

endmodule

FILE: hdl/bru_res_stage.sv
module bru_res_stage
  import bru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bru_s2_t          s2,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             taken,
  output logic [XLEN-1:0]  next_pc,
  output logic             misaligned,
  output logic             link_write,
  output logic [TAG_W-1:0] link_tag,
  output logic [XLEN-1:0]  link_value
);

  logic take;
  logic is_jump;
  logic mis;
  logic lw;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    unique case (s2.func)
      FUNC_JAL, FUNC_JALR: take = 1'b1;
      FUNC_BEQ:            take = s2.eq;
      FUNC_BNE:            take = !s2.eq;
      FUNC_BLT:            take = s2.lts;
      FUNC_BGE:            take = !s2.lts;
      FUNC_BLTU:           take = s2.ltu;
      FUNC_BGEU:           take = !s2.ltu;
      default:             take = 1'b0;
    endcase
    is_jump = (s2.func == FUNC_JAL) || (s2.func == FUNC_JALR);
    mis     = take && s2.target[1];
    lw      = is_jump && !mis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      taken      <= s2.inst_valid && take;
      next_pc    <= s2.inst_valid ? s2.target : '0;
      misaligned <= s2.inst_valid && mis;
      link_write <= s2.inst_valid && lw;
      link_tag   <= (s2.inst_valid && lw) ? s2.tag : '0;
      link_value <= (s2.inst_valid && lw) ? s2.link : '0;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(misaligned && !taken))
    else $error("misaligned without taken");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(link_write && misaligned))
    else $error("link write on misaligned target");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !next_pc[0])
    else $error("target bit 0 set");
  assert property (@(posedge clk) disable iff (rst)
      (in_valid && in_ready && s2.inst_valid && s2.func == FUNC_JAL) |=> taken)
    else $error("jal not taken");
`endif

endmodule

FILE: hdl/riscv_branch_resolve_unit.sv
// Branch resolve unit for RV64 control-transfer instructions.
// Input channel: in_valid/in_ready with func, inst_valid, pc, offset,
// src_a, src_b and dest_tag. An item with inst_valid low passes through
// and yields a result with every field zero.
// Output channel: out_valid/out_ready with taken, next_pc (target with
// bit 0 cleared), misaligned, link_write, link_tag and link_value (pc + 4).
// Pipeline of three stages from acceptance to out_valid: low-half adds and
// compares, high-half adds and compares with carry merge, then condition
// resolve into the output register.
// Throughput: one item per cycle while out_ready is high; each stage holds
// one item and takes a new one if empty or if its item moves on that cycle.
// Reset clears the stage valid bits; no item is lost or duplicated.
// When the receiver stalls, results back up stage by stage, in_ready drops
// once all three stages are full, and everything resumes as out_ready rises.
module riscv_branch_resolve_unit
  import bru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       func,
  input  logic             inst_valid,
  input  logic [XLEN-1:0]  pc,
  input  logic [XLEN-1:0]  offset,
  input  logic [XLEN-1:0]  src_a,
  input  logic [XLEN-1:0]  src_b,
  input  logic [TAG_W-1:0] dest_tag,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             taken,
  output logic [XLEN-1:0]  next_pc,
  output logic             misaligned,
  output logic             link_write,
  output logic [TAG_W-1:0] link_tag,
  output logic [XLEN-1:0]  link_value
);

  bru_s1_t s1;
  bru_s2_t s2;
  logic    v1;
  logic    v2;
  logic    r1;
  logic    r2;

  bru_lo_stage u_lo (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .inst_valid (inst_valid),
    .pc         (pc),
    .offset     (offset),
    .src_a      (src_a),
    .src_b      (src_b),
    .dest_tag   (dest_tag),
    .out_valid  (v1),
    .out_ready  (r1),
    .s1         (s1)
  );

  bru_hi_stage u_hi (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .s1        (s1),
    .out_valid (v2),
    .out_ready (r2),
    .s2        (s2)
  );

  bru_res_stage u_res (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .in_ready   (r2),
    .s2         (s2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .taken      (taken),
    .next_pc    (next_pc),
    .misaligned (misaligned),
    .link_write (link_write),
    .link_tag   (link_tag),
    .link_value (link_value)
  );

endmodule
